// ===== design/sorted_set_toggle_macros.svh =====
`ifndef SORTED_SET_TOGGLE_MACROS_SVH
`define SORTED_SET_TOGGLE_MACROS_SVH

// Assertion checked only while out of reset.
`define SST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Assertion checked at every edge, reset included.
`define SST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sst_pkg.sv =====
`timescale 1ns / 1ps
package sst_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int KEY_W     = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic KIND_TOGGLE = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] key;
  } in_t;

  typedef struct packed {
    logic       was_present;
    logic [4:0] entry_count;
    logic       dropped;
  } out_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic [1:0] op;
    key_t       key;
  } cell_cmd_t;

  // Compare results a cell reports.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_stat_t;

endpackage

// ===== design/sst_cell.sv =====
`timescale 1ns / 1ps
module sst_cell
  import sst_pkg::*;
(
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic       valid,
  input  logic       left_below,
  input  key_t       left_key,
  input  key_t       right_key,
  output cell_stat_t stat,
  output key_t       key_o
);

  key_t key_r;
  key_t key_nxt;

  assign stat.lt = valid && (key_r < cmd.key);
  assign stat.eq = valid && (key_r == cmd.key);
  assign key_o   = key_r;

  always_comb begin
    key_nxt = key_r;
    unique case (cmd.op)
      OP_INSERT: begin
        // cells below the key stay; the first one above takes it, the rest shift up
        if (!stat.lt) begin
          key_nxt = left_below ? cmd.key : left_key;
        end
      end
      OP_REMOVE: begin
        if (!stat.lt) begin
          key_nxt = right_key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== design/sorted_set_toggle.sv =====
`timescale 1ns / 1ps
// channel  | ports                        | beat
// ---------+------------------------------+----------------------------------
// input    | in_valid, in_stall, in_data  | kind, key
// output   | out_valid, out_stall, out_data | was_present, entry_count, dropped
//
// One beat per cycle while in_stall is low: cells compare the key at once and
// shift one place in the same cycle; a beat's result is registered on accept.
// The next beat sees the updated row, so back-to-back beats need no wait.
// Synchronous active-low reset empties the set (count goes to zero).
// in_stall is high during reset, and while a result sits in the output
// register and out_stall holds it there.
module sorted_set_toggle
  import sst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  cell_cmd_t  cmd;
  logic [1:0] cell_op;
  cell_stat_t stat  [CAPACITY];
  key_t       keys  [CAPACITY];
  logic       eq_vec [CAPACITY];
  logic [CAPACITY-1:0] eq_bits;

  logic accept;
  logic found;
  logic full;

  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));

  assign cmd = '{op: cell_op, key: KEY_W'(in_data.key)};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic valid_c;
    logic below_c;
    key_t left_c;
    key_t right_c;

    assign valid_c = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign below_c = 1'b1;
      assign left_c  = keys[i];
    end else begin : g_mid
      assign below_c = stat[i-1].lt;
      assign left_c  = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_c = keys[i];
    end else begin : g_inner
      assign right_c = keys[i+1];
    end

    sst_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (valid_c),
      .left_below (below_c),
      .left_key   (left_c),
      .right_key  (right_c),
      .stat       (stat[i]),
      .key_o      (keys[i])
    );

    assign eq_vec[i]  = stat[i].eq;
    assign eq_bits[i] = eq_vec[i];
  end

  assign found = |eq_bits;

  always_comb begin
    cell_op   = OP_HOLD;
    count_nxt = count_r;
    if (accept && in_data.kind == KIND_TOGGLE) begin
      if (found) begin
        cell_op   = OP_REMOVE;
        count_nxt = count_r - CNT_W'(1);
      end else if (!full) begin
        cell_op   = OP_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.was_present <= found;
      out_data_r.entry_count <= 5'(count_nxt);
      out_data_r.dropped     <= (in_data.kind == KIND_TOGGLE) && !found && full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/sst_checker.sv =====
`timescale 1ns / 1ps
`include "sorted_set_toggle_macros.svh"
module sst_checker
  import sst_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic out_wait;
  logic out_drop;
  logic at_cap;

  assign out_wait = out_valid && out_stall;
  assign out_drop = out_valid && out_data.dropped;
  assign at_cap   = (out_data.entry_count == 5'(CAPACITY));

  `SST_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
  `SST_ASSERT(a_out_hold, clk, rst_n, out_wait |=> out_valid && $stable(out_data), "result moved")
  `SST_ASSERT(a_drop_full, clk, rst_n, out_drop |-> at_cap, "drop while not full")
  `SST_ASSERT(a_drop_absent, clk, rst_n, out_drop |-> !out_data.was_present, "drop of a present key")
  `SST_ASSERT(a_stall_reason, clk, rst_n, in_stall |-> out_wait, "input held without a waiting result")

endmodule

bind sorted_set_toggle sst_checker u_sst_checker (.*);
